// File: hdl/olar_pkg.sv
`timescale 1ns / 1ps

package olar_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_APPENDED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_READ      = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                    append;
    logic                    remove;
    logic                    rotate;
    logic signed [VAL_W-1:0] key;
  } cell_cmd_t;

endpackage

// File: hdl/olar_in_if.sv
`timescale 1ns / 1ps

interface olar_in_if;
  import olar_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink (input valid, input operation, input value, output ready);

endinterface

// File: hdl/olar_out_if.sv
`timescale 1ns / 1ps

interface olar_out_if;
  import olar_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] item_value;
  logic [STAT_W-1:0]       status;
  logic                    list_empty;
  logic                    last;

  modport source (output valid, output item_value, output status, output list_empty,
                  output last, input ready);
  modport sink (input valid, input item_value, input status, input list_empty,
                input last, output ready);

endinterface

// File: hdl/ordered_list_append_remove.sv
`timescale 1ns / 1ps
// Append and remove: the result is registered and shows in the cycle after the item is
// taken, and a new item is taken every cycle while results are drained.
// Read-out of n values: the block takes no new item until the read state has loaded
// them, one per cycle while results are drained, as the cell ring turns by one.
// Reset clears the occupied flags and the count; stored values are not cleared.
module ordered_list_append_remove (
  input logic clk_i,
  input logic rst_ni,
  olar_in_if.sink    in_i,
  olar_out_if.source out_o
);
  import olar_pkg::*;

  state_e state_q, state_d;

  logic [CNT_W-1:0] count_q, rd_idx_q;
  logic             full, found, rd_last, out_free, in_ready, accept, load;
  op_e              op;
  cell_cmd_t        cmd;

  logic                    occ_w   [CAPACITY];
  logic                    match_w [CAPACITY];
  logic signed [VAL_W-1:0] value_w [CAPACITY];

  logic                    out_valid_q;
  logic signed [VAL_W-1:0] out_item_q, out_item_d;
  status_e                 out_status_q, out_status_d;
  logic                    out_empty_q, out_empty_d;
  logic                    out_last_q, out_last_d;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    prev_occ, match_in, next_occ;
    logic signed [VAL_W-1:0] next_value;

    if (i == 0) begin : g_head
      assign prev_occ = 1'b1;
      assign match_in = 1'b0;
    end else begin : g_body
      assign prev_occ = occ_w[i-1];
      assign match_in = match_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_occ   = 1'b0;
      assign next_value = '0;
    end else begin : g_inner
      assign next_occ   = occ_w[i+1];
      assign next_value = value_w[i+1];
    end

    olar_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .prev_occ_i   (prev_occ),
      .match_i      (match_in),
      .next_occ_i   (next_occ),
      .next_value_i (next_value),
      .head_value_i (value_w[0]),
      .occ_o        (occ_w[i]),
      .match_o      (match_w[i]),
      .value_o      (value_w[i])
    );
  end

  assign op       = op_e'(in_i.operation);
  assign full     = (count_q == CNT_W'(CAPACITY));
  assign found    = match_w[CAPACITY-1];
  assign rd_last  = ((rd_idx_q + CNT_W'(1)) == count_q);
  assign out_free = !out_valid_q || out_o.ready;
  assign accept   = in_i.valid && in_ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (op == OP_READ) && (count_q != '0)) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (out_free && rd_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    load         = 1'b0;
    cmd          = '{append: 1'b0, remove: 1'b0, rotate: 1'b0, key: in_i.value};
    out_item_d   = '0;
    out_status_d = ST_READ;
    out_empty_d  = 1'b0;
    out_last_d   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_ready = out_free;
        if (accept) begin
          unique case (op)
            OP_APPEND: begin
              cmd.append   = 1'b1;
              load         = 1'b1;
              out_status_d = full ? ST_FULL : ST_APPENDED;
              // A full list is never empty, so the list holds a value either way.
              out_empty_d  = 1'b0;
            end
            OP_REMOVE: begin
              cmd.remove   = 1'b1;
              load         = 1'b1;
              out_status_d = found ? ST_REMOVED : ST_NOT_FOUND;
              out_empty_d  = found ? (count_q == CNT_W'(1)) : (count_q == '0);
            end
            OP_READ: begin
              if (count_q == '0) begin
                load         = 1'b1;
                out_status_d = ST_READ;
                out_empty_d  = 1'b1;
              end
            end
            OP_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          load         = 1'b1;
          cmd.rotate   = 1'b1;
          out_item_d   = value_w[0];
          out_status_d = ST_READ;
          out_last_d   = rd_last;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd.append && !full) begin
        count_q <= count_q + CNT_W'(1);
      end else if (cmd.remove && found) begin
        count_q <= count_q - CNT_W'(1);
      end
      if (state_q == S_IDLE) begin
        rd_idx_q <= '0;
      end else if (load) begin
        rd_idx_q <= rd_idx_q + CNT_W'(1);
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_item_q   <= out_item_d;
      out_status_q <= out_status_d;
      out_empty_q  <= out_empty_d;
      out_last_q   <= out_last_d;
    end
  end

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.item_value = out_item_q;
  assign out_o.status     = out_status_q;
  assign out_o.list_empty = out_empty_q;
  assign out_o.last       = out_last_q;

endmodule

// File: hdl/olar_cell.sv
`timescale 1ns / 1ps

module olar_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  olar_pkg::cell_cmd_t               cmd_i,
  input  logic                              prev_occ_i,
  input  logic                              match_i,
  input  logic                              next_occ_i,
  input  logic signed [olar_pkg::VAL_W-1:0] next_value_i,
  input  logic signed [olar_pkg::VAL_W-1:0] head_value_i,
  output logic                              occ_o,
  output logic                              match_o,
  output logic signed [olar_pkg::VAL_W-1:0] value_o
);
  import olar_pkg::*;

  logic                    occ_q, occ_d;
  logic signed [VAL_W-1:0] value_q, value_d;
  logic                    hit;

  assign hit     = occ_q && (value_q == cmd_i.key);
  // Set in the first matching cell and in every cell behind it.
  assign match_o = match_i || hit;

  always_comb begin
    occ_d   = occ_q;
    value_d = value_q;
    priority if (cmd_i.append) begin
      // Only the first free cell sees an occupied neighbor on its left.
      if (!occ_q && prev_occ_i) begin
        occ_d   = 1'b1;
        value_d = cmd_i.key;
      end
    end else if (cmd_i.remove) begin
      if (match_o) begin
        occ_d   = next_occ_i;
        value_d = next_value_i;
      end
    end else if (cmd_i.rotate) begin
      // The tail cell wraps around to the head, so the list turns as a ring.
      if (occ_q) begin
        value_d = next_occ_i ? next_value_i : head_value_i;
      end
    end else begin
      // No command: the cell holds its contents.
      occ_d   = occ_q;
      value_d = value_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign occ_o   = occ_q;
  assign value_o = value_q;

endmodule

// File: dv/tb_ordered_list_append_remove.sv
`timescale 1ns / 1ps

module tb_ordered_list_append_remove;
  import olar_pkg::*;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam int STALL_LIMIT = 3000;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic signed [VAL_W-1:0] item_value;
    status_e                 status;
    logic                    list_empty;
    logic                    last;
  } list_result_t;

  // Keeps its own copy of the list and the results that the accepted items
  // must produce, oldest first.
  class list_scoreboard;
    logic signed [VAL_W-1:0] stored[$];
    list_result_t            pending[$];
    int unsigned             error_count;

    function void queue_result(logic signed [VAL_W-1:0] val, status_e st, logic empty,
                               logic last);
      list_result_t r;
      r.item_value = val;
      r.status     = st;
      r.list_empty = empty;
      r.last       = last;
      pending.push_back(r);
    endfunction

    function void note_input(op_e op, logic signed [VAL_W-1:0] val);
      int hit;
      hit = -1;
      case (op)
        OP_APPEND: begin
          if (stored.size() >= CAPACITY) begin
            queue_result('0, ST_FULL, stored.size() == 0, 1'b1);
          end else begin
            stored.push_back(val);
            queue_result('0, ST_APPENDED, 1'b0, 1'b1);
          end
        end
        OP_REMOVE: begin
          for (int i = 0; i < stored.size(); i++) begin
            if (stored[i] == val) begin
              hit = i;
              break;
            end
          end
          if (hit >= 0) begin
            stored.delete(hit);
            queue_result('0, ST_REMOVED, stored.size() == 0, 1'b1);
          end else begin
            queue_result('0, ST_NOT_FOUND, stored.size() == 0, 1'b1);
          end
        end
        OP_READ: begin
          if (stored.size() == 0) begin
            queue_result('0, ST_READ, 1'b1, 1'b1);
          end else begin
            for (int i = 0; i < stored.size(); i++)
              queue_result(stored[i], ST_READ, 1'b0, i == stored.size() - 1);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (pending.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("%0t: unexpected result: value %0d status %0d empty %0b last %0b",
                   $realtime, got.item_value, got.status, got.list_empty, got.last);
        return;
      end
      want = pending.pop_front();
      if (got.item_value !== want.item_value || got.status !== want.status ||
          got.list_empty !== want.list_empty || got.last !== want.last) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("%0t: expected %0d/%0d/%0b/%0b, got %0d/%0d/%0b/%0b",
                   $realtime, want.item_value, want.status, want.list_empty, want.last,
                   got.item_value, got.status, got.list_empty, got.last);
      end
    endfunction

    function bit clean();
      return error_count == 0 && pending.size() == 0;
    endfunction
  endclass

  logic clk;
  logic rst_n;

  olar_in_if  in_if ();
  olar_out_if out_if ();

  ordered_list_append_remove DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  list_scoreboard sb = new();

  int tx_idle_pct;
  int rx_stall_pct;
  int rx_hold_len;
  int stalled_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_len > 0) begin
        out_if.ready = 1'b0;
        repeat (rx_hold_len) @(negedge clk);
        rx_hold_len = 0;
      end
      out_if.ready = ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin : result_monitor
    list_result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.item_value = out_if.item_value;
      got.status     = status_e'(out_if.status);
      got.list_empty = out_if.list_empty;
      got.last       = out_if.last;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Offers one item from the falling edge on and returns at the rising edge
  // that accepts it.
  task automatic send_item(input op_e op, input logic signed [VAL_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid     = 1'b1;
    in_if.operation = op;
    in_if.value     = val;
    do @(posedge clk); while (!in_if.ready);
    sb.note_input(op, val);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Mixes full-range values with a small pool, so that removals hit
  // duplicates and the extremes turn up often.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(3))
      0, 3: return $urandom;
      1: return int'($urandom_range(7)) - 4;
      default: begin
        case ($urandom_range(3))
          0: return VAL_MAX;
          1: return VAL_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // Alternates stretches that fill the list with stretches that empty it.
  task automatic random_traffic(input int count);
    int   r;
    bit   draining;
    op_e  op;
    logic signed [VAL_W-1:0] val;
    for (int i = 0; i < count; i++) begin
      draining = (((i / 20) % 2) != 0);
      r = $urandom_range(99);
      if (r < (draining ? 20 : 55)) op = OP_APPEND;
      else if (r < 78) op = OP_REMOVE;
      else if (r < 95) op = OP_READ;
      else op = OP_NONE;
      val = pick_value();
      if (op == OP_REMOVE && sb.stored.size() != 0 && $urandom_range(9) < 6)
        val = sb.stored[$urandom_range(sb.stored.size() - 1)];
      send_item(op, val);
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.operation = OP_APPEND;
    in_if.value     = '0;
    tx_idle_pct     = 0;
    rx_stall_pct    = 0;
    rx_hold_len     = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_item(OP_READ, '0);
    send_item(OP_REMOVE, 7);
    send_item(OP_APPEND, VAL_MIN);
    send_item(OP_REMOVE, VAL_MIN);
    send_item(OP_NONE, $urandom);
    send_item(OP_APPEND, VAL_MAX);
    send_item(OP_APPEND, '1);
    send_item(OP_APPEND, '0);
    send_item(OP_APPEND, '1);
    send_item(OP_REMOVE, '1);
    send_item(OP_REMOVE, 12345);
    send_item(OP_READ, '0);
    for (int k = 0; k < 13; k++) send_item(OP_APPEND, $urandom);
    send_item(OP_APPEND, VAL_MIN);
    send_item(OP_READ, '0);
    wait_drained();

    // The result side holds off while items keep coming, so the block backs up.
    rx_hold_len = 60;
    random_traffic(60);
    wait_drained();

    tx_idle_pct = 81;
    random_traffic(60);
    wait_drained();

    tx_idle_pct  = 0;
    rx_stall_pct = 81;
    random_traffic(60);
    wait_drained();

    tx_idle_pct  = 22;
    rx_stall_pct = 22;
    random_traffic(60);
    wait_drained();

    repeat (20) @(posedge clk);
    if (sb.clean()) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
